[design/pd_eval_pkg.sv]
// shared types, constants and helper functions of the polynomial derivative evaluator
`default_nettype none
package pd_eval_pkg;

  localparam int DATA_W     = 32;
  localparam int ORD_W      = 4;
  localparam int ORD_LEVELS = 1 << ORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int FF_W       = 33;
  localparam int SAT_IN_W   = 72;
  localparam int PROD_W     = 2 * DATA_W;

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = (72'sd1 <<< (DATA_W - 1)) - 72'sd1;
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -(72'sd1 <<< (DATA_W - 1));

  typedef logic signed [DATA_W-1:0] pd_word_t;

  // running state that travels down the pipeline with each beat
  typedef struct packed {
    pd_word_t         x;
    logic [ORD_W-1:0] ord;
    pd_word_t         r;
    logic             ovf;
  } pd_data_t;

  typedef struct packed {
    pd_word_t value;
    logic     ovf;
  } pd_sat_t;

  // clamp a wide signed value to the 32-bit range
  function automatic pd_sat_t pd_sat(input logic signed [SAT_IN_W-1:0] v);
    pd_sat_t s;
    if (v > SAT_MAX) begin
      s.value = pd_word_t'(SAT_MAX);
      s.ovf   = 1'b1;
    end else if (v < SAT_MIN) begin
      s.value = pd_word_t'(SAT_MIN);
      s.ovf   = 1'b1;
    end else begin
      s.value = pd_word_t'(v);
      s.ovf   = 1'b0;
    end
    return s;
  endfunction

  // falling factorial i(i-1)..(i-o+1), capped at 2^32 (any nonzero coefficient saturates there)
  function automatic logic [FF_W-1:0] ff_cap(input int i, input int o);
    longint acc;
    int     j;
    acc = 1;
    for (j = 0; j < o; j++) begin
      acc = acc * longint'(i - j);
      if (acc > (longint'(1) << DATA_W)) acc = longint'(1) << DATA_W;
    end
    return acc[FF_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/pd_point_if.sv]
// input channel carrying evaluation points and derivative orders
`default_nettype none
interface pd_point_if;
  import pd_eval_pkg::*;

  logic             valid;
  logic             ready;
  pd_word_t         x_value;
  logic [ORD_W-1:0] derivative_order;

  modport source(output valid, x_value, derivative_order, input ready);
  modport sink(input valid, x_value, derivative_order, output ready);
endinterface
`default_nettype wire

[design/pd_result_if.sv]
// output channel carrying derivative values and the overflow flag
`default_nettype none
interface pd_result_if;
  import pd_eval_pkg::*;

  logic     valid;
  logic     ready;
  pd_word_t result_value;
  logic     overflow;

  modport source(output valid, result_value, overflow, input ready);
  modport sink(input valid, result_value, overflow, output ready);
endinterface
`default_nettype wire

[design/poly_derivative_eval.sv]
// top level: coefficient registers, scaling stage and the chain of horner steps
//
//   channel     dir   beat contents
//   point_ch    in    x_value (Q15.16), derivative_order (0..15)
//   result_ch   out   result_value (Q15.16, saturated), overflow
//   write port  in    write_enable, write_index, write_data (coef_i)
//
// one beat enters per cycle while no stage is stalled; the pipeline is the scaling stage and
// two stages per horner step (multiply, round and add).
// rst clears every stage valid bit and all coefficients to zero.
// each stage holds its beat while the next is full, so bubbles close up under a stall
// and nothing is dropped or repeated.
`default_nettype none
module poly_derivative_eval #(
  parameter int NUM_COEFFS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              write_enable,
  input  wire logic [pd_eval_pkg::CFG_IDX_W-1:0] write_index,
  input  wire pd_eval_pkg::pd_word_t             write_data,
  pd_point_if.sink                               point_ch,
  pd_result_if.source                            result_ch
);
  import pd_eval_pkg::*;

  pd_word_t coef [NUM_COEFFS];

  logic     link_valid [NUM_COEFFS];
  logic     link_ready [NUM_COEFFS];
  pd_data_t link_data  [NUM_COEFFS];
  pd_word_t link_d     [NUM_COEFFS][NUM_COEFFS];

  // coefficient registers; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFFS; i++) coef[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_COEFFS; i++) begin
        if (write_enable && int'(write_index) == i) coef[i] <= write_data;
      end
    end
  end

  // scaling stage
  pd_scale #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_ch.valid),
    .in_ready  (point_ch.ready),
    .x         (point_ch.x_value),
    .ord       (point_ch.derivative_order),
    .coef      (coef),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0]),
    .out_d     (link_d[0])
  );

  // horner steps from the second-highest coefficient down to the constant term
  for (genvar s = 1; s < NUM_COEFFS; s++) begin : g_step
    pd_horner_step #(
      .NUM_COEFFS (NUM_COEFFS),
      .FRAC_BITS  (FRAC_BITS),
      .STEP_K     (NUM_COEFFS - 1 - s)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[s-1]),
      .in_ready  (link_ready[s-1]),
      .in_data   (link_data[s-1]),
      .in_d      (link_d[s-1]),
      .out_valid (link_valid[s]),
      .out_ready (link_ready[s]),
      .out_data  (link_data[s]),
      .out_d     (link_d[s])
    );
  end

  // last add stage is the output register
  assign link_ready[NUM_COEFFS-1] = result_ch.ready;
  assign result_ch.valid          = link_valid[NUM_COEFFS-1];
  assign result_ch.result_value   = link_data[NUM_COEFFS-1].r;
  assign result_ch.overflow       = link_data[NUM_COEFFS-1].ovf;

  // order past the top coefficient gives a clean zero
  a_high_order_zero: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && int'(link_data[NUM_COEFFS-1].ord) >= NUM_COEFFS
    |-> result_ch.result_value == '0 && !result_ch.overflow)
    else $error("high order beat did not give zero");

  // an empty output stage means the whole chain can take a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_ch.valid |-> point_ch.ready)
    else $error("input stalled with empty output stage");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_ch.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[design/pd_scale.sv]
// first stage: scales every coefficient by its falling factorial for the beat's order
`default_nettype none
module pd_scale #(
  parameter int NUM_COEFFS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire pd_eval_pkg::pd_word_t          x,
  input  wire logic [pd_eval_pkg::ORD_W-1:0]  ord,
  input  wire pd_eval_pkg::pd_word_t          coef [NUM_COEFFS],
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      pd_eval_pkg::pd_data_t          out_data,
  output      pd_eval_pkg::pd_word_t          out_d [NUM_COEFFS]
);
  import pd_eval_pkg::*;

  pd_word_t               d_next [NUM_COEFFS];
  logic [NUM_COEFFS-1:0]  ovf_vec;
  logic                   valid;
  pd_data_t               data;
  pd_word_t               d [NUM_COEFFS];

  // one multiplier per coefficient against its factorial table row
  for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_coef
    logic [FF_W-1:0]                ff_row [ORD_LEVELS];
    logic signed [DATA_W+FF_W:0]    prod;
    pd_sat_t                        s;

    for (genvar o = 0; o < ORD_LEVELS; o++) begin : g_ord
      localparam logic [FF_W-1:0] FF_KO = ff_cap(k, o);
      assign ff_row[o] = FF_KO;
    end

    assign prod       = coef[k] * $signed({1'b0, ff_row[ord]});
    assign s          = pd_sat(SAT_IN_W'(prod));
    assign d_next[k]  = s.value;
    assign ovf_vec[k] = s.ovf;
  end

  // stage register
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.x   <= x;
      data.ord <= ord;
      data.r   <= d_next[NUM_COEFFS-1];
      data.ovf <= |ovf_vec;
      d        <= d_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;
  assign out_d     = d;

endmodule
`default_nettype wire

[design/pd_horner_step.sv]
// one horner step over two stages: multiply, then round, saturate and add
`default_nettype none
module pd_horner_step #(
  parameter int NUM_COEFFS = 8,
  parameter int FRAC_BITS  = 16,
  parameter int STEP_K     = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire pd_eval_pkg::pd_data_t  in_data,
  input  wire pd_eval_pkg::pd_word_t  in_d [NUM_COEFFS],
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      pd_eval_pkg::pd_data_t  out_data,
  output      pd_eval_pkg::pd_word_t  out_d [NUM_COEFFS]
);
  import pd_eval_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

  logic                     m_valid;
  logic                     m_ready;
  pd_data_t                 m_data;
  pd_word_t                 m_d [NUM_COEFFS];
  logic signed [PROD_W-1:0] m_prod;
  logic signed [PROD_W-1:0] prod;

  logic                     a_valid;
  logic                     a_ready;
  pd_data_t                 a_data;
  pd_word_t                 a_d [NUM_COEFFS];
  pd_data_t                 a_next;

  logic                     active;
  logic signed [PROD_W-1:0] rounded;
  logic signed [DATA_W:0]   sum;
  pd_sat_t                  s_mul;
  pd_sat_t                  s_add;

  // multiply stage
  assign prod    = $signed(in_data.r) * $signed(in_data.x);
  assign m_ready = !m_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_data <= in_data;
      m_d    <= in_d;
      m_prod <= prod;
    end
  end

  // round to nearest, saturate, add the next scaled coefficient; skipped below the order
  always_comb begin
    active  = int'(m_data.ord) <= STEP_K;
    rounded = (m_prod + HALF) >>> FRAC_BITS;
    s_mul   = pd_sat(SAT_IN_W'(rounded));
    sum     = (DATA_W + 1)'($signed(s_mul.value)) + (DATA_W + 1)'($signed(m_d[STEP_K]));
    s_add   = pd_sat(SAT_IN_W'(sum));
    a_next  = m_data;
    if (active) begin
      a_next.r   = s_add.value;
      a_next.ovf = m_data.ovf | s_mul.ovf | s_add.ovf;
    end
  end

  // add stage
  assign a_ready = !a_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && m_valid) begin
      a_data <= a_next;
      a_d    <= m_d;
    end
  end

  assign in_ready  = m_ready;
  assign out_valid = a_valid;
  assign out_data  = a_data;
  assign out_d     = a_d;

endmodule
`default_nettype wire

[tb/sv/tb_poly_derivative_eval.sv]
// self-checking testbench for the polynomial derivative evaluator
`timescale 1ns / 100ps
module tb_poly_derivative_eval;
  import pd_eval_pkg::*;

  localparam int N_COEFS     = 8;
  localparam int FRAC        = 16;
  localparam int LATENCY     = 1 + 2 * (N_COEFS - 1);
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS  = 100;
  localparam int TIMEOUT_NS  = 3_000_000;

  localparam longint WORD_MAX   = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN   = -(longint'(1) <<< (DATA_W - 1));
  localparam longint ROUND_HALF = longint'(1) <<< (FRAC - 1);

  localparam pd_word_t WORD_HI = 32'sh7fff_ffff;
  localparam pd_word_t WORD_LO = 32'sh8000_0000;
  localparam pd_word_t ONE_Q   = 32'sh0001_0000;
  localparam pd_word_t HALF_Q  = 32'sh0000_8000;

  typedef enum int {
    COEFS_RAMP,
    COEFS_MAX,
    COEFS_MIN,
    COEFS_MIXED,
    COEFS_SMALL,
    COEFS_WIDE
  } coef_set_e;

  typedef struct {
    pd_word_t         x;
    logic [ORD_W-1:0] ord;
  } point_t;

  typedef struct {
    pd_word_t value;
    logic     ovf;
  } deriv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration write port
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  pd_word_t             cfg_data = '0;

  // channel drive state
  logic             pt_valid = 1'b0;
  pd_word_t         pt_x     = '0;
  logic [ORD_W-1:0] pt_ord   = '0;
  logic             rs_ready = 1'b0;

  pd_point_if  point_ch ();
  pd_result_if result_ch ();

  assign point_ch.valid            = pt_valid;
  assign point_ch.x_value          = pt_x;
  assign point_ch.derivative_order = pt_ord;
  assign result_ch.ready           = rs_ready;

  poly_derivative_eval #(
    .NUM_COEFFS (N_COEFS),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (cfg_we),
    .write_index  (cfg_idx),
    .write_data   (cfg_data),
    .point_ch     (point_ch),
    .result_ch    (result_ch)
  );

  // coefficient copy, points waiting to go out, derivatives waiting to come back
  pd_word_t coef_shadow [N_COEFS];
  point_t   pending_points [$];
  deriv_t   expected_derivs [$];

  int send_gap_pct   = 0;
  int recv_gap_pct   = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int mismatch_count = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // clamp to the signed 32-bit range, noting any clipping
  function automatic longint clamp_word(longint v, inout bit clipped);
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // coefficient times the falling factorial, clipped at every multiply
  function automatic longint scaled_coef(int idx, int ord, inout bit clipped);
    longint d;
    int     j;
    d = longint'(coef_shadow[idx]);
    for (j = 0; j < ord; j++) d = clamp_word(d * longint'(idx - j), clipped);
    return d;
  endfunction

  // horner evaluation of the ord-th derivative at x
  function automatic deriv_t eval_derivative(pd_word_t x, logic [ORD_W-1:0] ord_in);
    deriv_t res;
    longint acc;
    longint dk;
    bit     clipped;
    int     ord;
    int     k;
    ord     = int'(ord_in);
    clipped = 1'b0;
    acc     = 0;
    if (ord < N_COEFS) begin
      acc = scaled_coef(N_COEFS - 1, ord, clipped);
      for (k = N_COEFS - 2; k >= ord; k--) begin
        acc = clamp_word(((acc * longint'(x)) + ROUND_HALF) >>> FRAC, clipped);
        dk  = scaled_coef(k, ord, clipped);
        acc = clamp_word(acc + dk, clipped);
      end
    end
    res.value = pd_word_t'(acc);
    res.ovf   = clipped;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // point driver: predict on every accepted beat, then offer the next one
  always @(posedge clk) begin
    point_t nxt;
    if (rst) begin
      pt_valid <= 1'b0;
    end else begin
      if (pt_valid && point_ch.ready) expected_derivs.push_back(eval_derivative(pt_x, pt_ord));
      if (!pt_valid || point_ch.ready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_points.pop_front();
          pt_valid <= 1'b1;
          pt_x     <= nxt.x;
          pt_ord   <= nxt.ord;
        end else begin
          pt_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each beat, then pick ready for the next cycle
  always @(posedge clk) begin
    deriv_t want;
    if (rst) begin
      rs_ready <= 1'b0;
    end else begin
      if (result_ch.valid && rs_ready) begin
        if (expected_derivs.size() == 0) begin
          flag_mismatch($sformatf("result %h ovf %b with nothing pending",
                                  result_ch.result_value, result_ch.overflow));
        end else begin
          want = expected_derivs.pop_front();
          if (result_ch.result_value !== want.value)
            flag_mismatch($sformatf("result_value %h, predicted %h",
                                    result_ch.result_value, want.value));
          if (result_ch.overflow !== want.ovf)
            flag_mismatch($sformatf("overflow %b, predicted %b (value %h)",
                                    result_ch.overflow, want.ovf, want.value));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_seen != hold_seq) begin
        hold_seen <= hold_seq;
        hold_left <= HOLD_CYCLES;
        rs_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rs_ready  <= 1'b0;
      end else begin
        rs_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  function automatic pd_word_t random_x();
    pd_word_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: return pd_word_t'(int'($urandom_range(0, 262144)) - 131072);
      4, 5: return pd_word_t'($urandom);
      6, 7: begin
        v = ONE_Q + pd_word_t'(int'($urandom_range(0, 8192)) - 4096);
        return ($urandom_range(1) != 0) ? v : -v;
      end
      default: begin
        case ($urandom_range(6))
          0: return '0;
          1: return WORD_HI;
          2: return WORD_LO;
          3: return HALF_Q;
          4: return -HALF_Q;
          5: return ONE_Q;
          default: return -ONE_Q;
        endcase
      end
    endcase
  endfunction

  // mostly meaningful orders, some beyond the polynomial degree
  function automatic logic [ORD_W-1:0] random_ord();
    if ($urandom_range(3) != 0) return ORD_W'($urandom_range(N_COEFS - 1));
    return ORD_W'($urandom_range(ORD_LEVELS - 1));
  endfunction

  task automatic queue_point(pd_word_t x, int ord);
    point_t p;
    p.x   = x;
    p.ord = ORD_W'(ord);
    pending_points.push_back(p);
  endtask

  // write all coefficient registers while the pipeline is empty
  task automatic load_coefs(coef_set_e kind);
    pd_word_t v;
    int       i;
    for (i = 0; i < N_COEFS; i++) begin
      case (kind)
        COEFS_RAMP: begin
          v = pd_word_t'((i + 1) * 32768);
          if (i % 2 != 0) v = -v;
        end
        COEFS_MAX:   v = WORD_HI;
        COEFS_MIN:   v = WORD_LO;
        COEFS_MIXED: v = (i % 2 != 0) ? WORD_LO : WORD_HI;
        COEFS_SMALL: v = pd_word_t'(int'($urandom_range(0, 524288)) - 262144);
        default:     v = pd_word_t'($urandom);
      endcase
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= v;
      coef_shadow[i] = v;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every beat to go out and come back, then let the pipe flush
  task automatic settle();
    while (pending_points.size() != 0 || pt_valid || expected_derivs.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic run_phase(coef_set_e kind, int n_items, int snd_pct, int rcv_pct,
                           bit squeeze);
    int n;
    load_coefs(kind);
    send_gap_pct = snd_pct;
    recv_gap_pct = rcv_pct;
    for (n = 0; n < n_items; n++) queue_point(random_x(), random_ord());
    if (squeeze) hold_seq++;
    settle();
  endtask

  // stimulus sequence
  initial begin
    pd_word_t corner_x [10];
    int       i;
    corner_x = '{'0, ONE_Q, -ONE_Q, WORD_HI, WORD_LO, HALF_Q, -HALF_Q,
                 32'sh0002_0000, 32'shfffd_8000, 32'sh0000_0001};
    for (i = 0; i < N_COEFS; i++) coef_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // coefficients still at reset
    send_gap_pct = 27;
    recv_gap_pct = 67;
    queue_point(WORD_HI, 0);
    queue_point(WORD_LO, 3);
    queue_point(ONE_Q, 7);
    settle();

    // every order over the corner points, then saturating extremes and rounding ties
    load_coefs(COEFS_RAMP);
    for (i = 0; i < ORD_LEVELS; i++) queue_point(corner_x[i % 10], i);
    queue_point(WORD_HI, 0);
    queue_point(WORD_LO, 1);
    queue_point(HALF_Q, 0);
    queue_point(32'sh0000_0001, 0);
    queue_point(WORD_HI, N_COEFS - 1);
    queue_point(WORD_LO, N_COEFS - 2);
    settle();

    // random phases across coefficient sets and idle mixes
    run_phase(COEFS_MAX, 150, 27, 67, 1'b0);
    run_phase(COEFS_MIN, 150, 67, 27, 1'b0);
    run_phase(COEFS_MIXED, 100, 67, 27, 1'b0);
    run_phase(COEFS_SMALL, 250, 67, 27, 1'b0);
    run_phase(COEFS_WIDE, 200, 0, 0, 1'b1);
    run_phase(COEFS_SMALL, 250, 0, 0, 1'b1);

    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && expected_derivs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", expected_derivs.size());
    $display("FAIL");
    $finish;
  end

endmodule
